@@ rtl/vobc_pkg.sv @@
package vobc_pkg;

  // Midpoint of the biased velocity scale (zero velocity).
  localparam logic [7:0] MIDPOINT = 8'd129;

  // Default limit on groups reported in one radial.
  localparam int DEFAULT_MAX_GROUPS = 256;

  // Register word indexes on the configuration port.
  localparam logic REG_VELOCITY_OFFSET = 1'b0;
  localparam logic REG_BINS_PER_GROUP  = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [8:0] OFFSET_RESET = 9'd0;
  localparam logic [2:0] BPG_RESET    = 3'd2;

  // One input bin.
  typedef struct packed {
    logic [8:0] raw_velocity;
    logic       radial_end;
    logic       clear_extremes;
  } in_item_t;

  // One compacted group result.
  typedef struct packed {
    logic [7:0] group_value;
    logic [8:0] group_number;
    logic [7:0] most_negative;
    logic [7:0] most_positive;
  } out_item_t;

endpackage

@@ rtl/velocity_offset_bin_compactor.sv @@
// A bin is first registered in the input stage; its group result is then registered
// in the result register. Throughput: one bin per cycle while the output does not stall;
// the group state is updated combinationally from the registered bin. Stalls on the
// output hold the input stage. rst_n is synchronous and active low: it clears the group
// and product state to the midpoint, empties both stages and resets the registers.
module velocity_offset_bin_compactor
  import vobc_pkg::*;
#(
  parameter int MAX_GROUPS = DEFAULT_MAX_GROUPS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CNT_W = $clog2(MAX_GROUPS + 1);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_GROUPS);

  // Configuration registers
  logic [8:0] offset_r;
  logic [2:0] bpg_r;

  // Input stage
  logic     s1_valid_r;
  in_item_t s1_item_r;

  // Group and product state
  logic [1:0]       bin_count_r, bin_count_nxt;
  logic [7:0]       group_low_r, group_low_nxt;
  logic [7:0]       group_high_r, group_high_nxt;
  logic [3:0]       group_flags_r, group_flags_nxt;
  logic [CNT_W-1:0] group_cnt_r, group_cnt_nxt;
  logic [7:0]       ext_low_r, ext_low_nxt;
  logic [7:0]       ext_high_r, ext_high_nxt;

  // Output stage
  logic      out_valid_r;
  out_item_t out_item_r, out_item_nxt;
  logic      emit;

  logic out_free;
  logic advance;

  // Configuration port: always ready, writes on the access phase.
  assign pready = 1'b1;

  always_comb begin
    case (paddr[2])
      REG_VELOCITY_OFFSET: prdata = {23'd0, offset_r};
      REG_BINS_PER_GROUP:  prdata = {29'd0, bpg_r};
      default:             prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= OFFSET_RESET;
      bpg_r    <= BPG_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_VELOCITY_OFFSET: offset_r <= pwdata[8:0];
        REG_BINS_PER_GROUP:  bpg_r    <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  // Pipeline control: the registered bin is processed once the output slot is free.
  assign out_free = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_data;
    end
  end

  // Group update for the registered bin.
  always_comb begin
    logic signed [10:0] off_sat;
    logic signed [10:0] sum;
    logic [7:0]         code;
    logic [2:0]         size;
    logic [2:0]         filled;
    logic               done;
    logic               take_low;
    logic [9:0]         mag_sum;
    logic [7:0]         val;
    logic [7:0]         lo_base;
    logic [7:0]         hi_base;

    // Saturate the offset to the legal span.
    off_sat = {{2{offset_r[8]}}, offset_r};
    if (off_sat < -11'sd254) begin
      off_sat = -11'sd254;
    end else if (off_sat > 11'sd254) begin
      off_sat = 11'sd254;
    end

    // Remap the code: no data, folded, or clamped shifted velocity.
    sum = $signed({2'b00, s1_item_r.raw_velocity}) + off_sat;
    if (s1_item_r.raw_velocity == 9'd0 || s1_item_r.raw_velocity[8]) begin
      code = 8'd0;
    end else if (s1_item_r.raw_velocity == 9'd1) begin
      code = 8'd1;
    end else if (sum < 11'sd2) begin
      code = 8'd2;
    end else if (sum > 11'sd255) begin
      code = 8'd255;
    end else begin
      code = sum[7:0];
    end

    // Group size, with out-of-range settings held to one or four.
    if (bpg_r == 3'd0) begin
      size = 3'd1;
    end else if (bpg_r > 3'd4) begin
      size = 3'd4;
    end else begin
      size = bpg_r;
    end

    group_low_nxt   = group_low_r;
    group_high_nxt  = group_high_r;
    group_flags_nxt = group_flags_r;
    group_cnt_nxt   = group_cnt_r;

    // Product extremes restart before this bin when asked.
    if (s1_item_r.clear_extremes) begin
      lo_base = MIDPOINT;
      hi_base = MIDPOINT;
    end else begin
      lo_base = ext_low_r;
      hi_base = ext_high_r;
    end
    ext_low_nxt  = lo_base;
    ext_high_nxt = hi_base;

    // Fold the bin into the group.
    if (code == 8'd1) begin
      group_flags_nxt[1] = 1'b1;
    end else if (code > 8'd1) begin
      group_flags_nxt[0] = 1'b1;
      if (code < group_low_r) begin
        group_low_nxt      = code;
        group_flags_nxt[2] = 1'b1;
      end else if (code > group_high_r) begin
        group_high_nxt     = code;
        group_flags_nxt[3] = 1'b1;
      end
    end

    filled        = {1'b0, bin_count_r} + 3'd1;
    done          = (filled >= size);
    bin_count_nxt = filled[1:0];

    // Choose the group value: a side alone past the midpoint wins; else low wins if low + high < 257.
    mag_sum = {2'b00, group_high_nxt} + {2'b00, group_low_nxt};
    if (group_flags_nxt[2] && !group_flags_nxt[3]) begin
      take_low = 1'b1;
    end else if (!group_flags_nxt[2] && group_flags_nxt[3]) begin
      take_low = 1'b0;
    end else begin
      take_low = (mag_sum < 10'd257);
    end

    val  = 8'd0;
    emit = 1'b0;
    if (done) begin
      if (group_flags_nxt[0]) begin
        if (take_low) begin
          val = group_low_nxt;
          if (val < lo_base) begin
            ext_low_nxt = val;
          end
        end else begin
          val = group_high_nxt;
          if (val > hi_base) begin
            ext_high_nxt = val;
          end
        end
      end else if (group_flags_nxt[1]) begin
        val = 8'd1;
      end

      if (group_cnt_r < CNT_LIMIT) begin
        group_cnt_nxt = group_cnt_r + CNT_W'(1);
        emit          = 1'b1;
      end
    end

    out_item_nxt.group_value   = val;
    out_item_nxt.group_number  = 9'(group_cnt_nxt);
    out_item_nxt.most_negative = ext_low_nxt;
    out_item_nxt.most_positive = ext_high_nxt;

    // A completed group or the radial end starts a fresh group.
    if (done || s1_item_r.radial_end) begin
      bin_count_nxt   = 2'd0;
      group_low_nxt   = MIDPOINT;
      group_high_nxt  = MIDPOINT;
      group_flags_nxt = 4'd0;
    end
    if (s1_item_r.radial_end) begin
      group_cnt_nxt = '0;
    end
  end

  // State registers advance only when a bin is processed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_count_r   <= 2'd0;
      group_low_r   <= MIDPOINT;
      group_high_r  <= MIDPOINT;
      group_flags_r <= 4'd0;
      group_cnt_r   <= '0;
      ext_low_r     <= MIDPOINT;
      ext_high_r    <= MIDPOINT;
    end else if (advance) begin
      bin_count_r   <= bin_count_nxt;
      group_low_r   <= group_low_nxt;
      group_high_r  <= group_high_nxt;
      group_flags_r <= group_flags_nxt;
      group_cnt_r   <= group_cnt_nxt;
      ext_low_r     <= ext_low_nxt;
      ext_high_r    <= ext_high_nxt;
    end
  end

  // Result register: filled by a completed group within the group limit, emptied by a transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= advance && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import vobc_pkg::*;

  localparam int GROUP_LIMIT = DEFAULT_MAX_GROUPS;
  localparam int HOLD_CYCLES = 200;
  localparam int SETTLE_CYCLES = 4;

  // Special input codes of the biased velocity scale.
  localparam int CODE_NO_DATA = 0;
  localparam int CODE_FOLDED = 1;
  localparam int CODE_MISSING = 256;
  localparam int CODE_LOWEST = 2;
  localparam int CODE_HIGHEST = 255;
  localparam int OFFSET_LIMIT = 254;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Bins waiting to be sent and group results waiting to arrive.
  in_item_t  pending_bins[$];
  out_item_t expected_groups[$];

  int bins_queued = 0;
  int bins_accepted = 0;
  int groups_checked = 0;
  int settings_used = 0;
  int errors = 0;
  int hold_left = 0;
  bit hold_request = 1'b0;
  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;

  // Predictor copy of the registers and of the compaction state.
  logic [8:0] offset_reg = OFFSET_RESET;
  logic [2:0] group_size_reg = BPG_RESET;
  int bins_in_group;
  int group_low;
  int group_high;
  bit seen_good;
  bit seen_folded;
  bit seen_low;
  bit seen_high;
  int groups_in_radial = 0;
  int product_low = MIDPOINT;
  int product_high = MIDPOINT;

  velocity_offset_bin_compactor #(
    .MAX_GROUPS(GROUP_LIMIT)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  function automatic void clear_group();
    bins_in_group = 0;
    group_low = MIDPOINT;
    group_high = MIDPOINT;
    seen_good = 1'b0;
    seen_folded = 1'b0;
    seen_low = 1'b0;
    seen_high = 1'b0;
  endfunction

  initial clear_group();

  // Maps one raw bin onto the offset scale: no data 0, folded 1, else 2..255.
  function automatic int shifted_code(input logic [8:0] raw);
    int off;
    int code;
    off = $signed(offset_reg);
    if (off < -OFFSET_LIMIT) off = -OFFSET_LIMIT;
    if (off > OFFSET_LIMIT) off = OFFSET_LIMIT;
    if (raw == CODE_NO_DATA || raw >= CODE_MISSING) return CODE_NO_DATA;
    if (raw == CODE_FOLDED) return CODE_FOLDED;
    code = int'(raw) + off;
    if (code < CODE_LOWEST) code = CODE_LOWEST;
    if (code > CODE_HIGHEST) code = CODE_HIGHEST;
    return code;
  endfunction

  // Adds one bin to the current group and returns 1 when a group result is due.
  function automatic bit compact_bin(input in_item_t b, output out_item_t grp);
    int size;
    int code;
    int chosen;
    bit take_low;
    bit made;
    made = 1'b0;
    grp = '0;
    size = group_size_reg;
    if (size < 1) size = 1;
    if (size > 4) size = 4;
    if (b.clear_extremes) begin
      product_low = MIDPOINT;
      product_high = MIDPOINT;
    end
    code = shifted_code(b.raw_velocity);
    if (code == CODE_FOLDED) begin
      seen_folded = 1'b1;
    end else if (code > CODE_FOLDED) begin
      seen_good = 1'b1;
      if (code < group_low) begin
        group_low = code;
        seen_low = 1'b1;
      end else if (code > group_high) begin
        group_high = code;
        seen_high = 1'b1;
      end
    end
    bins_in_group++;
    if (bins_in_group >= size) begin
      if (seen_good) begin
        if (seen_low && !seen_high) take_low = 1'b1;
        else if (!seen_low && seen_high) take_low = 1'b0;
        else take_low = group_high < (2 * MIDPOINT - 1 - group_low);
        if (take_low) begin
          chosen = group_low;
          if (chosen < product_low) product_low = chosen;
        end else begin
          chosen = group_high;
          if (chosen > product_high) product_high = chosen;
        end
      end else if (seen_folded) begin
        chosen = CODE_FOLDED;
      end else begin
        chosen = CODE_NO_DATA;
      end
      if (groups_in_radial < GROUP_LIMIT) begin
        groups_in_radial++;
        grp.group_value = 8'(chosen);
        grp.group_number = 9'(groups_in_radial);
        grp.most_negative = 8'(product_low);
        grp.most_positive = 8'(product_high);
        made = 1'b1;
      end
      clear_group();
    end
    if (b.radial_end) begin
      clear_group();
      groups_in_radial = 0;
    end
    return made;
  endfunction

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    errors++;
  endtask

  // Sender: offers queued bins, with random gaps between transfers.
  always @(posedge clk) begin : drive_bins
    logic next_valid;
    int gap_left;
    out_item_t grp;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      next_valid = in_valid;
      if (in_valid && !in_stall) begin
        if (compact_bin(in_data, grp)) expected_groups.push_back(grp);
        bins_accepted++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_bins.size() > 0) begin
          in_data <= pending_bins.pop_front();
          next_valid = 1'b1;
          if (send_idle && $urandom_range(0, 2) == 0) gap_left = gap_length();
        end
      end
      in_valid <= next_valid;
    end
  end

  // Long hold-off of the result side, counted here in cycles.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_request) begin
      hold_left <= HOLD_CYCLES;
      hold_request = 1'b0;
    end
  end

  // Receiver: checks each result transfer and stalls at random.
  always @(posedge clk) begin : watch_groups
    int stall_left;
    bit stall_now;
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_groups.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: %h", out_data));
        end else begin
          want = expected_groups.pop_front();
          groups_checked++;
          if (out_data.group_value !== want.group_value)
            report_mismatch($sformatf("group_value %0d, expected %0d",
                                      out_data.group_value, want.group_value));
          if (out_data.group_number !== want.group_number)
            report_mismatch($sformatf("group_number %0d, expected %0d",
                                      out_data.group_number, want.group_number));
          if (out_data.most_negative !== want.most_negative)
            report_mismatch($sformatf("most_negative %0d, expected %0d",
                                      out_data.most_negative, want.most_negative));
          if (out_data.most_positive !== want.most_positive)
            report_mismatch($sformatf("most_positive %0d, expected %0d",
                                      out_data.most_positive, want.most_positive));
        end
      end
      if (stall_left == 0 && recv_idle && $urandom_range(0, 3) == 0)
        stall_left = gap_length();
      stall_now = stall_left > 0;
      if (stall_left > 0) stall_left--;
      out_stall <= stall_now || (hold_left != 0);
    end
  end

  // Register write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic index, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (index == REG_VELOCITY_OFFSET) offset_reg = value[8:0];
    else group_size_reg = value[2:0];
  endtask

  task automatic set_registers(input logic [8:0] off9, input logic [2:0] size);
    write_reg(REG_VELOCITY_OFFSET, 32'($signed(off9)));
    write_reg(REG_BINS_PER_GROUP, {29'd0, size});
    settings_used++;
  endtask

  task automatic push_bin(input int raw, input bit last, input bit clr);
    in_item_t b;
    b.raw_velocity = 9'(raw);
    b.radial_end = last;
    b.clear_extremes = clr;
    pending_bins.push_back(b);
    bins_queued++;
  endtask

  // One radial of random bins, closed by a radial end mark when asked.
  task automatic push_radial(input int len, input bit close);
    int r;
    int raw;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 12) raw = CODE_NO_DATA;
      else if (r < 20) raw = CODE_FOLDED;
      else if (r < 24) raw = $urandom_range(CODE_MISSING, 511);
      else if (r < 60) raw = $urandom_range(100, 160);
      else raw = $urandom_range(CODE_LOWEST, CODE_HIGHEST);
      push_bin(raw, close && (i == len - 1), $urandom_range(0, 19) == 0);
    end
  endtask

  // Waits until every bin is taken and every result has arrived.
  task automatic wait_idle();
    while (bins_accepted != bins_queued || expected_groups.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [8:0] off9;
    int phase_start;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: no data, folded, equal magnitudes, all at midpoint.
    push_bin(CODE_NO_DATA, 0, 1);
    push_bin(CODE_MISSING, 0, 0);
    push_bin(CODE_FOLDED, 0, 0);
    push_bin(CODE_FOLDED, 0, 0);
    push_bin(CODE_FOLDED, 0, 0);
    push_bin(200, 0, 0);
    push_bin(CODE_LOWEST, 0, 0);
    push_bin(CODE_HIGHEST, 0, 0);
    push_bin(MIDPOINT, 0, 0);
    push_bin(MIDPOINT, 0, 0);
    push_bin(60, 0, 0);
    push_bin(160, 0, 0);
    push_bin(300, 0, 0);
    push_bin(511, 0, 0);
    push_bin(50, 1, 0);
    push_bin(77, 0, 0);
    wait_idle();

    // Offset beyond the positive limit and an oversized group, entered mid group.
    set_registers(9'd255, 3'd7);
    push_bin(3, 0, 0);
    push_bin(CODE_FOLDED, 0, 0);
    push_bin(CODE_NO_DATA, 0, 0);
    push_bin(128, 1, 0);
    wait_idle();

    // Offset beyond the negative limit and a group size of zero.
    set_registers(9'h100, 3'd0);
    push_bin(CODE_HIGHEST, 0, 0);
    push_bin(CODE_LOWEST, 0, 0);
    push_bin(CODE_MISSING, 0, 0);
    push_bin(MIDPOINT, 1, 1);
    wait_idle();

    // Random radials under a range of register settings.
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: off9 = 9'h100;
        1: off9 = 9'd255;
        3: off9 = 9'(-OFFSET_LIMIT);
        4: off9 = 9'(OFFSET_LIMIT);
        5: off9 = 9'd0;
        default: off9 = 9'($urandom_range(0, 511));
      endcase
      set_registers(off9, 3'(p));
      send_idle = (p != 5) && ($urandom_range(0, 3) != 0);
      recv_idle = (p != 5) && ($urandom_range(0, 3) != 0);
      if (p == 2) hold_request = 1'b1;
      phase_start = bins_queued;
      while (bins_queued - phase_start < 135) begin
        if ($urandom_range(0, 7) == 0) push_radial($urandom_range(25, 60),
                                                   $urandom_range(0, 9) != 0);
        else push_radial($urandom_range(1, 24), $urandom_range(0, 9) != 0);
      end
      wait_idle();
    end

    // A radial longer than the group limit, then a short one to show the restart.
    send_idle = 1'b1;
    recv_idle = 1'b1;
    set_registers(9'($urandom_range(0, 511)), 3'd1);
    push_radial(GROUP_LIMIT + 6, 1);
    push_radial(10, 1);
    wait_idle();

    $display("Run covered %0d bins under %0d register settings; %0d group results compared.",
             bins_accepted, settings_used + 1, groups_checked);
    if (errors == 0) begin
      $display("** velocity_offset_bin_compactor: PASSED **");
    end else begin
      $display("** velocity_offset_bin_compactor: FAILED **");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5_000_000;
    $display("Timed out with %0d results outstanding.", expected_groups.size());
    $display("** velocity_offset_bin_compactor: FAILED **");
    $finish;
  end

endmodule
